>>> rtl/bba_pkg.sv
// buddy block allocator package: tree node codes, opcodes and result type
// used by the engine and the top level; no dependencies
package bba_pkg;
   localparam logic [1:0] NODE_UNUSED = 2'd0;
   localparam logic [1:0] NODE_FREE   = 2'd1;
   localparam logic [1:0] NODE_USED   = 2'd2;
   localparam logic [1:0] NODE_SPLIT  = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam int REQ_SIZE_W = 12;
   localparam int ADDR_W     = 10;
   localparam int SIZE_W     = 11;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] granted_address;
      logic [SIZE_W-1:0] granted_size;
   } result_type;
endpackage

>>> rtl/bba_tree_ram.sv
// node code memory of the buddy tree: one write port, one registered read port
// uses no package
module bba_tree_ram #(
   parameter int ADDR_BITS = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [1:0]           wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [1:0]           rd_data
);
   logic [1:0] mem [0:(2**ADDR_BITS)-1];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/bba_engine.sv
// sequencer of the buddy allocator: clearing pass, level scan, split and merge
// depends on bba_pkg and bba_tree_ram
module bba_engine #(
   parameter int POOL_UNITS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              opcode,
   input  logic [bba_pkg::REQ_SIZE_W-1:0]    request_size,
   input  logic [bba_pkg::ADDR_W-1:0]        block_address,
   output logic                              idle,
   input  logic                              slot_free,
   output logic                              done,
   output bba_pkg::result_type               result
);
   import bba_pkg::*;

   localparam int PLOG = $clog2(POOL_UNITS + 1) - 1;
   localparam int POOL = 1 << PLOG;
   localparam int NW   = PLOG + 1;
   localparam int LW   = $clog2(PLOG + 1);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_ROOT = 4'd1;
   localparam logic [3:0] S_IDLE = 4'd2;
   localparam logic [3:0] S_ARD  = 4'd3;
   localparam logic [3:0] S_ACK  = 4'd4;
   localparam logic [3:0] S_SW1  = 4'd5;
   localparam logic [3:0] S_SW2  = 4'd6;
   localparam logic [3:0] S_AUSE = 4'd7;
   localparam logic [3:0] S_FRD  = 4'd8;
   localparam logic [3:0] S_FCK  = 4'd9;
   localparam logic [3:0] S_MRD  = 4'd10;
   localparam logic [3:0] S_MCK  = 4'd11;
   localparam logic [3:0] S_MW2  = 4'd12;
   localparam logic [3:0] S_MW3  = 4'd13;
   localparam logic [3:0] S_DONE = 4'd14;

   logic [3:0]      state_ff, state_in;
   logic [NW-1:0]   node_ff, node_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   logic [LW-1:0]   need_ff, need_in;
   logic [PLOG-1:0] addr_ff, addr_in;
   result_type      res_ff, res_in;

   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [1:0]    wr_data;
   logic [NW-1:0] rd_addr;
   logic [1:0]    rd_data;

   logic [LW-1:0] need_lvl;
   logic [NW:0]   node_inc;
   logic [NW-1:0] grant_pos;
   logic [31:0]   grant_addr32;
   logic [31:0]   grant_size32;
   logic [PLOG-1:0] low_mask;
   logic          addr_bit;

   function automatic logic addr_bit_sel(input logic [PLOG-1:0] a, input logic [LW-1:0] l);
      logic [PLOG-1:0] sh;
      sh = a >> (l - 1'b1);
      return sh[0];
   endfunction

   bba_tree_ram #(.ADDR_BITS(NW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // log2 of the request rounded up, zero taken as one
   always_comb begin
      need_lvl = '0;
      for (int k = 0; k < PLOG; k++) begin
         if ((32'd1 << k) < 32'(request_size)) begin
            need_lvl = LW'(k + 1);
         end
      end
   end

   assign node_inc     = {1'b0, node_ff} + 1'b1;
   assign grant_pos    = node_ff << need_ff;
   assign grant_addr32 = 32'(grant_pos[PLOG-1:0]);
   assign grant_size32 = 32'd1 << need_ff;
   assign low_mask     = PLOG'((32'd1 << lvl_ff) - 32'd1);
   assign addr_bit     = addr_bit_sel(addr_ff, lvl_ff);

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      lvl_in   = lvl_ff;
      need_in  = need_ff;
      addr_in  = addr_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = node_ff;
      wr_data  = NODE_UNUSED;
      rd_addr  = node_ff;
      done     = 1'b0;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            node_in = node_ff + 1'b1;
            if (&node_ff) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            wr_en    = 1'b1;
            wr_addr  = NW'(1);
            wr_data  = NODE_FREE;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               res_in = '0;
               if (opcode == OP_ALLOC) begin
                  need_in = need_lvl;
                  lvl_in  = need_lvl;
                  node_in = NW'(1) << (LW'(PLOG) - need_lvl);
                  if (32'(request_size) > 32'(POOL)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_ARD;
                  end
               end else begin
                  addr_in = PLOG'(32'(block_address));
                  node_in = NW'(1);
                  lvl_in  = LW'(PLOG);
                  if (32'(block_address) >= 32'(POOL)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FRD;
                  end
               end
            end
         end
         S_ARD: state_in = S_ACK;
         S_ACK: begin
            if (rd_data == NODE_FREE) begin
               state_in = (lvl_ff > need_ff) ? S_SW1 : S_AUSE;
            end else if ((node_inc[NW-1:0] & node_ff) == '0) begin
               // end of this level, go one size up
               if (lvl_ff == LW'(PLOG)) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in   = lvl_ff + 1'b1;
                  node_in  = NW'(node_inc >> 2);
                  state_in = S_ARD;
               end
            end else begin
               node_in  = node_inc[NW-1:0];
               state_in = S_ARD;
            end
         end
         S_SW1: begin
            wr_en    = 1'b1;
            wr_data  = NODE_SPLIT;
            state_in = S_SW2;
         end
         S_SW2: begin
            wr_en    = 1'b1;
            wr_addr  = {node_ff[NW-2:0], 1'b1};
            wr_data  = NODE_FREE;
            node_in  = {node_ff[NW-2:0], 1'b0};
            lvl_in   = lvl_ff - 1'b1;
            state_in = ((lvl_ff - 1'b1) > need_ff) ? S_SW1 : S_AUSE;
         end
         S_AUSE: begin
            wr_en   = 1'b1;
            wr_data = NODE_USED;
            res_in.ok              = 1'b1;
            res_in.granted_address = grant_addr32[ADDR_W-1:0];
            res_in.granted_size    = grant_size32[SIZE_W-1:0];
            state_in = S_DONE;
         end
         S_FRD: state_in = S_FCK;
         S_FCK: begin
            if (rd_data == NODE_SPLIT && lvl_ff != '0) begin
               lvl_in   = lvl_ff - 1'b1;
               node_in  = {node_ff[NW-2:0], addr_bit};
               state_in = S_FRD;
            end else if ((addr_ff & low_mask) != '0 || rd_data == NODE_UNUSED
                         || rd_data == NODE_SPLIT) begin
               state_in = S_DONE;
            end else begin
               wr_en     = 1'b1;
               wr_data   = NODE_FREE;
               res_in.ok = 1'b1;
               state_in  = (node_ff == NW'(1)) ? S_DONE : S_MRD;
            end
         end
         S_MRD: begin
            rd_addr  = node_ff ^ NW'(1);
            state_in = S_MCK;
         end
         S_MCK: begin
            if (rd_data == NODE_FREE) begin
               wr_en    = 1'b1;
               state_in = S_MW2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MW2: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff ^ NW'(1);
            node_in  = node_ff >> 1;
            state_in = S_MW3;
         end
         S_MW3: begin
            wr_en    = 1'b1;
            wr_data  = NODE_FREE;
            state_in = (node_ff == NW'(1)) ? S_DONE : S_MRD;
         end
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         node_ff  <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
      end
      lvl_ff  <= lvl_in;
      need_ff <= need_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign result = res_ff;
endmodule

>>> rtl/buddy_block_allocator.sv
// buddy allocator over a pool of POOL_UNITS units (largest power of two not above)
// allocate scans the nodes of the needed level, then each level up, for a free node, splits it
// down to the needed size and marks the block used; free walks down the tree to the block,
// marks it free and merges it with its buddy while the buddy is free, up to the root
// throughput: one word at a time, not ready while a word is in work or its result waits for the output slot
// reset: clearing pass over all 2*pool words of the node memory, then the root is marked free
module buddy_block_allocator #(
   parameter int POOL_UNITS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // opcode, request_size[11:0], block_address[9:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // ok, granted_address[9:0], granted_size[10:0]
);
   import bba_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       eng_idle;
   logic       eng_done;
   logic       slot_free;
   result_type eng_result;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   bba_engine #(.POOL_UNITS(POOL_UNITS)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (req_tvalid && eng_idle),
      .opcode        (req_tdata[0]),
      .request_size  (req_tdata[12:1]),
      .block_address (req_tdata[22:13]),
      .idle          (eng_idle),
      .slot_free     (slot_free),
      .done          (eng_done),
      .result        (eng_result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_done) begin
         rsp_in       = eng_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_tready = eng_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.granted_size, rsp_ff.granted_address, rsp_ff.ok};
endmodule

>>> test/tb_buddy_block_allocator.sv
// testbench for buddy_block_allocator: directed table then random allocate/free traffic,
// every response checked against its typed row or the in-bench model; depends on bba_pkg
module tb_buddy_block_allocator;
   import bba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 1024;

   typedef struct {
      logic        op;
      logic [11:0] size;
      logic [9:0]  addr;
      bit          typed;
      result_type  want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // opcode, request_size[11:0], block_address[9:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // ok, granted_address[9:0], granted_size[10:0]

   logic [1:0]  pool_tree [0:2*POOL-1];
   result_type  pending_grants [$];
   int          live_blocks [$];
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   logic        hold_off = 1'b0;
   int          accepted = 0;
   int          mismatches = 0;
   bit          typed_next = 1'b0;
   result_type  typed_want;

   buddy_block_allocator dut (.*);

   always #1 clock = ~clock;

   // buddy tree update for one word, returns the response it should produce
   function automatic result_type apply_request(logic op, logic [11:0] size, logic [9:0] addr);
      result_type r;
      int need, s, first, node, nsz, i, start, span;
      r = '0;
      if (op == OP_ALLOC) begin
         if (size > POOL) return r;
         need = 1;
         while (need < size) need <<= 1;
         node = 0;
         nsz = 0;
         for (s = need; s <= POOL && node == 0; s <<= 1) begin
            first = POOL / s;
            for (i = first; i < 2 * first; i++)
               if (node == 0 && pool_tree[i] == NODE_FREE) begin
                  node = i;
                  nsz = s;
               end
         end
         if (node == 0) return r;
         while (nsz > need) begin
            pool_tree[node] = NODE_SPLIT;
            pool_tree[2*node+1] = NODE_FREE;
            node = 2 * node;
            pool_tree[node] = NODE_FREE;
            nsz >>= 1;
         end
         pool_tree[node] = NODE_USED;
         r.ok = 1'b1;
         r.granted_address = ADDR_W'((node - POOL / nsz) * nsz);
         r.granted_size = SIZE_W'(nsz);
         return r;
      end
      node = 1;
      start = 0;
      span = POOL;
      while (pool_tree[node] == NODE_SPLIT && span > 1) begin
         span >>= 1;
         if (addr >= start + span) begin
            start += span;
            node = 2 * node + 1;
         end else begin
            node = 2 * node;
         end
      end
      if (start != addr || pool_tree[node] == NODE_UNUSED || pool_tree[node] == NODE_SPLIT)
         return r;
      pool_tree[node] = NODE_FREE;
      while (node > 1 && pool_tree[node ^ 1] == NODE_FREE) begin
         pool_tree[node] = NODE_UNUSED;
         pool_tree[node ^ 1] = NODE_UNUSED;
         node >>= 1;
         pool_tree[node] = NODE_FREE;
      end
      r.ok = 1'b1;
      return r;
   endfunction

   // accepted request words
   always @(posedge clock) begin
      result_type r;
      int k;
      if (!reset && req_tvalid && req_tready) begin
         r = apply_request(req_tdata[0], req_tdata[12:1], req_tdata[22:13]);
         if (r.ok && req_tdata[0] == OP_ALLOC) live_blocks.push_back(r.granted_address);
         if (r.ok && req_tdata[0] == OP_FREE)
            for (k = live_blocks.size() - 1; k >= 0; k--)
               if (live_blocks[k] == req_tdata[22:13]) live_blocks.delete(k);
         pending_grants.push_back(typed_next ? typed_want : r);
         accepted <= accepted + 1;
      end
   end

   // response words
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok              = rsp_tdata[0];
         got.granted_address = rsp_tdata[10:1];
         got.granted_size    = rsp_tdata[21:11];
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            want = pending_grants.pop_front();
            if (got.ok !== want.ok || got.granted_address !== want.granted_address ||
                got.granted_size !== want.granted_size) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected ok=%0d addr=%0d size=%0d, got ok=%0d addr=%0d size=%0d",
                           want.ok, want.granted_address, want.granted_size,
                           got.ok, got.granted_address, got.granted_size);
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

   // long receiver hold-off so the block backs up its input
   initial begin
      wait (accepted >= 150);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #50ms;
      $display("buddy_block_allocator verification failed");
      $finish;
   end

   task automatic send_word(logic op, logic [11:0] size, logic [9:0] addr,
                            bit typed, result_type want);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, addr, size, op};
      typed_next <= typed;
      typed_want <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic result_type grant(logic ok, int a, int s);
      result_type r;
      r.ok = ok;
      r.granted_address = ADDR_W'(a);
      r.granted_size = SIZE_W'(s);
      return r;
   endfunction

   initial begin
      row_type rows [$];
      logic        op;
      logic [11:0] size;
      logic [9:0]  addr;
      int n, sel;
      for (n = 0; n < 2 * POOL; n++) pool_tree[n] = NODE_UNUSED;
      pool_tree[1] = NODE_FREE;
      rows = '{
         '{OP_ALLOC, 12'd2048, 10'd0,    1, grant(0, 0, 0)},     // over the pool
         '{OP_ALLOC, 12'd4095, 10'd1023, 1, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd1025, 10'd0,    1, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd1024, 10'd0,    1, grant(1, 0, 1024)},  // whole pool
         '{OP_ALLOC, 12'd0,    10'd0,    1, grant(0, 0, 0)},     // pool full
         '{OP_FREE,  12'd0,    10'd1023, 1, grant(0, 0, 0)},     // not a block start
         '{OP_FREE,  12'd4095, 10'd0,    1, grant(1, 0, 0)},
         '{OP_FREE,  12'd0,    10'd0,    1, grant(1, 0, 0)},     // free of a free block
         '{OP_ALLOC, 12'd0,    10'd0,    1, grant(1, 0, 1)},     // zero taken as one
         '{OP_ALLOC, 12'd1,    10'd0,    0, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd3,    10'd0,    0, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd512,  10'd0,    0, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd257,  10'd0,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd2,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd1,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd4,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd0,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd512,  0, grant(0, 0, 0)},
         '{OP_ALLOC, 12'd1023, 10'd0,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd0,    0, grant(0, 0, 0)},
         '{OP_FREE,  12'd0,    10'd0,    0, grant(0, 0, 0)}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_word(rows[i].op, rows[i].size, rows[i].addr,
                                  rows[i].typed, rows[i].want);
      for (n = 0; n < 900; n++) begin
         case (n / 225)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 52; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 52; end
            default: begin send_gap_pct = 9; stall_pct = 9; end
         endcase
         if (live_blocks.size() < 4 || $urandom_range(0, 1) == 0) begin
            op = OP_ALLOC;
            sel = $urandom_range(0, 99);
            if (sel < 60)      size = $urandom_range(0, 16);
            else if (sel < 85) size = $urandom_range(17, 128);
            else if (sel < 95) size = $urandom_range(129, 1024);
            else               size = $urandom_range(1025, 4095);
            addr = $urandom_range(0, 1023);
         end else begin
            op = OP_FREE;
            size = $urandom_range(0, 4095);
            if ($urandom_range(0, 99) < 75)
               addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            else
               addr = $urandom_range(0, 1023);
         end
         send_word(op, size, addr, 0, grant(0, 0, 0));
      end
      req_tvalid <= 1'b0;
      // let the last accepted word reach the expected queue first
      @(posedge clock);
      wait (pending_grants.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("buddy_block_allocator verification clean");
      end else begin
         $display("buddy_block_allocator verification failed");
      end
      $finish;
   end
endmodule
